// ===== rtl/fvams_pkg.sv =====
// ----------------------------------------------------------------------------
// fvams_pkg
// Types and constants for the face vapor area block.
// ----------------------------------------------------------------------------
package fvams_pkg;

  localparam int FRAC_W   = 17;
  localparam int SPAN_W   = 24;
  localparam int AREA_W   = 48;
  localparam int CORNER_W = 19;
  localparam int DVS_W    = 20;
  localparam int PROD_W   = 45;
  localparam int REM_W    = 21;
  localparam int Q_W      = 24;
  localparam int CRS_W    = 50;
  localparam int SUM_W    = 52;
  localparam int D2_W     = 53;

  localparam logic [CORNER_W-1:0] HALF_SUM    = 19'd131072;
  localparam logic [FRAC_W-1:0]   CENTRE_HALF = 17'd32768;

  typedef struct packed {
    logic [3:0]        below;
    logic              centre_lo;
    logic [SPAN_W-1:0] su;
    logic [SPAN_W-1:0] sv;
  } face_ctl_t;

  typedef struct packed {
    logic [SPAN_W-1:0] u;
    logic [SPAN_W-1:0] v;
  } pt_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic use_pl;
    logic quad;
    logic hex;
  } face_mode_t;

endpackage

// ===== rtl/face_vapor_area_marching_square.sv =====
// ----------------------------------------------------------------------------
// face_vapor_area_marching_square
// Marching-squares vapor area of one wall face from a 3x3 fraction patch.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the four 24-step edge-crossing dividers
// are fully pipelined, one quotient bit per stage.
// The whole pipeline stalls together while an output word waits.
// Reset clears all valid bits; data registers are not reset.
module face_vapor_area_marching_square (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_lo_lo,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_mid_lo,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_hi_lo,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_lo_mid,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_mid,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_hi_mid,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_lo_hi,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_mid_hi,
  input  logic [fvams_pkg::FRAC_W-1:0] cell_hi_hi,
  input  logic [fvams_pkg::SPAN_W-1:0] span_u,
  input  logic [fvams_pkg::SPAN_W-1:0] span_v,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fvams_pkg::AREA_W-1:0] vapor_area
);
  import fvams_pkg::*;

  localparam logic [1:0] CYC_NODE [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
  localparam logic [1:0] EDGE_LO  [4] = '{2'd0, 2'd1, 2'd2, 2'd0};
  localparam logic [1:0] EDGE_HI  [4] = '{2'd1, 2'd3, 2'd3, 2'd2};

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: corner sums
  logic                s1_val;
  logic [CORNER_W-1:0] s1_c [4];
  face_ctl_t           s1_ctl;
  logic [CORNER_W-1:0] c_next [4];

  always_comb begin
    c_next[0] = CORNER_W'(cell_lo_lo) + CORNER_W'(cell_mid_lo)
              + CORNER_W'(cell_lo_mid) + CORNER_W'(cell_mid);
    c_next[1] = CORNER_W'(cell_mid_lo) + CORNER_W'(cell_hi_lo)
              + CORNER_W'(cell_mid) + CORNER_W'(cell_hi_mid);
    c_next[2] = CORNER_W'(cell_lo_mid) + CORNER_W'(cell_mid)
              + CORNER_W'(cell_lo_hi) + CORNER_W'(cell_mid_hi);
    c_next[3] = CORNER_W'(cell_mid) + CORNER_W'(cell_hi_mid)
              + CORNER_W'(cell_mid_hi) + CORNER_W'(cell_hi_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_val <= 1'b0;
    end else if (adv) begin
      s1_val <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s1_c[i]         <= c_next[i];
        s1_ctl.below[i] <= c_next[i] < HALF_SUM;
      end
      s1_ctl.centre_lo <= cell_mid < CENTRE_HALF;
      s1_ctl.su        <= span_u;
      s1_ctl.sv        <= span_v;
    end
  end

  // stage 2 and divider chain
  logic            dval [Q_W+1];
  face_ctl_t       dctl [Q_W+1];
  logic [REM_W-1:0] drem [Q_W+1][4];
  logic [DVS_W-1:0] ddvs [Q_W+1][4];
  logic [Q_W-1:0]   dqn  [Q_W+1][4];

  logic [PROD_W-1:0] n_next [4];
  logic [DVS_W-1:0]  d_next [4];

  always_comb begin
    logic [CORNER_W-1:0] nr, fr, num, den;
    logic [SPAN_W-1:0]   sp;
    for (int e = 0; e < 4; e++) begin
      nr  = s1_c[EDGE_LO[e]];
      fr  = s1_c[EDGE_HI[e]];
      num = (nr > HALF_SUM) ? nr - HALF_SUM : HALF_SUM - nr;
      den = (fr > nr) ? fr - nr : nr - fr;
      sp  = (e == 0 || e == 2) ? s1_ctl.su : s1_ctl.sv;
      n_next[e] = ((PROD_W'(sp) * PROD_W'(num)) << 1) + PROD_W'(den);
      d_next[e] = {den, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dval[0] <= 1'b0;
    end else if (adv) begin
      dval[0] <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dctl[0] <= s1_ctl;
      for (int e = 0; e < 4; e++) begin
        drem[0][e] <= n_next[e][PROD_W-1:Q_W];
        dqn[0][e]  <= n_next[e][Q_W-1:0];
        ddvs[0][e] <= d_next[e];
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [REM_W-1:0] rem_next [4];
    logic [Q_W-1:0]   qn_next  [4];

    always_comb begin
      logic [REM_W:0] t;
      logic           ge;
      for (int e = 0; e < 4; e++) begin
        t  = {drem[k][e], dqn[k][e][Q_W-1]};
        ge = t >= (REM_W+1)'(ddvs[k][e]);
        rem_next[e] = ge ? REM_W'(t - (REM_W+1)'(ddvs[k][e])) : REM_W'(t);
        qn_next[e]  = {dqn[k][e][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dval[k+1] <= 1'b0;
      end else if (adv) begin
        dval[k+1] <= dval[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dctl[k+1] <= dctl[k];
        for (int e = 0; e < 4; e++) begin
          drem[k+1][e] <= rem_next[e];
          dqn[k+1][e]  <= qn_next[e];
          ddvs[k+1][e] <= ddvs[k][e];
        end
      end
    end
  end

  // stage 3: polygon point list
  face_ctl_t  fc;
  pt_t        pos [4];
  pt_t        xpt [4];
  pt_t        lst [8];
  face_mode_t mode_next;
  logic [2:0] nbelow;
  logic       diag;

  assign fc = dctl[Q_W];

  always_comb begin
    logic [3:0] cnt;
    pos[0] = '{u: '0,    v: '0};
    pos[1] = '{u: fc.su, v: '0};
    pos[2] = '{u: '0,    v: fc.sv};
    pos[3] = '{u: fc.su, v: fc.sv};
    xpt[0] = '{u: dqn[Q_W][0], v: '0};
    xpt[1] = '{u: fc.su,       v: dqn[Q_W][1]};
    xpt[2] = '{u: dqn[Q_W][2], v: fc.sv};
    xpt[3] = '{u: '0,          v: dqn[Q_W][3]};
    nbelow = 3'(fc.below[0]) + 3'(fc.below[1]) + 3'(fc.below[2]) + 3'(fc.below[3]);
    diag   = (fc.below == 4'b1001) || (fc.below == 4'b0110);
    mode_next.full   = nbelow == 3'd4;
    mode_next.empty  = nbelow == 3'd0;
    mode_next.use_pl = (nbelow == 3'd3) || (diag && !fc.centre_lo);
    mode_next.quad   = (nbelow == 3'd2) && !diag;
    mode_next.hex    = diag;
    for (int i = 0; i < 8; i++) begin
      lst[i] = '0;
    end
    cnt = '0;
    for (int k = 0; k < 4; k++) begin
      if (fc.below[CYC_NODE[k]] ^ mode_next.use_pl) begin
        lst[cnt[2:0]] = pos[CYC_NODE[k]];
        cnt = cnt + 4'd1;
      end
      if (fc.below[EDGE_LO[k]] != fc.below[EDGE_HI[k]]) begin
        lst[cnt[2:0]] = xpt[k];
        cnt = cnt + 4'd1;
      end
    end
  end

  logic        s3_val;
  pt_t         s3_p [6];
  face_mode_t  s3_mode;
  logic [AREA_W-1:0] s3_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_val <= 1'b0;
    end else if (adv) begin
      s3_val <= dval[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        s3_p[i] <= lst[i];
      end
      s3_mode <= mode_next;
      s3_face <= AREA_W'(fc.su) * AREA_W'(fc.sv);
    end
  end

  // stage 4: triangle products
  logic signed [CRS_W-1:0] m1_next [4];
  logic signed [CRS_W-1:0] m2_next [4];

  always_comb begin
    pt_t a, b, c;
    logic signed [SPAN_W:0] du1, dv1, du2, dv2;
    for (int t = 0; t < 4; t++) begin
      unique case (t)
        0: begin
          a = s3_p[0]; b = s3_p[1]; c = s3_p[2];
        end
        1: begin
          if (s3_mode.quad) begin
            a = s3_p[0]; b = s3_p[2]; c = s3_p[3];
          end else begin
            a = s3_p[2]; b = s3_p[3]; c = s3_p[4];
          end
        end
        2: begin
          a = s3_p[4]; b = s3_p[5]; c = s3_p[0];
        end
        default: begin
          a = s3_p[0]; b = s3_p[2]; c = s3_p[4];
        end
      endcase
      du1 = $signed({1'b0, b.u}) - $signed({1'b0, a.u});
      dv1 = $signed({1'b0, b.v}) - $signed({1'b0, a.v});
      du2 = $signed({1'b0, c.u}) - $signed({1'b0, a.u});
      dv2 = $signed({1'b0, c.v}) - $signed({1'b0, a.v});
      m1_next[t] = CRS_W'(du1) * CRS_W'(dv2);
      m2_next[t] = CRS_W'(dv1) * CRS_W'(du2);
    end
  end

  logic                    s4_val;
  logic signed [CRS_W-1:0] s4_m1 [4];
  logic signed [CRS_W-1:0] s4_m2 [4];
  logic [3:0]              s4_en;
  face_mode_t              s4_mode;
  logic [AREA_W-1:0]       s4_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_val <= 1'b0;
    end else if (adv) begin
      s4_val <= s3_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m1   <= m1_next;
      s4_m2   <= m2_next;
      s4_en   <= {s3_mode.hex, s3_mode.hex, s3_mode.hex || s3_mode.quad, 1'b1};
      s4_mode <= s3_mode;
      s4_face <= s3_face;
    end
  end

  // stage 5: absolute cross products
  logic [CRS_W-1:0] ab_next [4];

  always_comb begin
    logic signed [CRS_W:0] x;
    for (int t = 0; t < 4; t++) begin
      x = (CRS_W+1)'(s4_m1[t]) - (CRS_W+1)'(s4_m2[t]);
      if (!s4_en[t]) begin
        ab_next[t] = '0;
      end else if (x < 0) begin
        ab_next[t] = CRS_W'(-x);
      end else begin
        ab_next[t] = CRS_W'(x);
      end
    end
  end

  logic              s5_val;
  logic [CRS_W-1:0]  s5_ab [4];
  face_mode_t        s5_mode;
  logic [AREA_W-1:0] s5_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_val <= 1'b0;
    end else if (adv) begin
      s5_val <= s4_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ab   <= ab_next;
      s5_mode <= s4_mode;
      s5_face <= s4_face;
    end
  end

  // stage 6: sum of doubled areas
  logic              s6_val;
  logic [SUM_W-1:0]  s6_sum;
  face_mode_t        s6_mode;
  logic [AREA_W-1:0] s6_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_val <= 1'b0;
    end else if (adv) begin
      s6_val <= s5_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sum  <= SUM_W'(s5_ab[0]) + SUM_W'(s5_ab[1]) + SUM_W'(s5_ab[2]) + SUM_W'(s5_ab[3]);
      s6_mode <= s5_mode;
      s6_face <= s5_face;
    end
  end

  // stage 7: complement and clamp at zero
  logic signed [D2_W-1:0] d2_next;

  always_comb begin
    if (s6_mode.use_pl) begin
      d2_next = $signed({4'b0, s6_face, 1'b0}) - $signed({1'b0, s6_sum});
    end else begin
      d2_next = $signed({1'b0, s6_sum});
    end
    if (d2_next < 0) begin
      d2_next = '0;
    end
  end

  logic              s7_val;
  logic [SUM_W-1:0]  s7_d2;
  face_mode_t        s7_mode;
  logic [AREA_W-1:0] s7_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_val <= 1'b0;
    end else if (adv) begin
      s7_val <= s6_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_d2   <= SUM_W'(d2_next);
      s7_mode <= s6_mode;
      s7_face <= s6_face;
    end
  end

  // output: round, limit to face area; full gives face, empty gives zero
  logic [SUM_W-1:0]  half_d2;
  logic [AREA_W-1:0] area_next;

  always_comb begin
    half_d2 = SUM_W'(({1'b0, s7_d2} + (SUM_W+1)'(1)) >> 1);
    if (s7_mode.full) begin
      area_next = s7_face;
    end else if (s7_mode.empty) begin
      area_next = '0;
    end else if (half_d2 > SUM_W'(s7_face)) begin
      area_next = s7_face;
    end else begin
      area_next = half_d2[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s7_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vapor_area <= area_next;
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for face_vapor_area_marching_square. A directed table
// covers the extremes, the uniform faces and both saddle resolutions; random
// faces follow, mostly with cells near one half so that every marching-squares
// case is hit. Each output word is compared with a table or predicted area.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fvams_pkg::*;

  localparam int N_RANDOM = 1830;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_DIR = 14;

  localparam int CYC_NODE[4] = '{0, 1, 3, 2};
  localparam int EDGE_LO[4] = '{0, 1, 2, 0};
  localparam int EDGE_HI[4] = '{1, 3, 3, 2};
  localparam bit EDGE_ON_U[4] = '{1'b1, 1'b0, 1'b1, 1'b0};

  typedef struct {
    logic [FRAC_W-1:0] f [9];
    logic [SPAN_W-1:0] su;
    logic [SPAN_W-1:0] sv;
    bit                known;
    logic [AREA_W-1:0] area;
  } face_t;

  typedef struct {
    longint u;
    longint v;
  } fpt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FRAC_W-1:0] frac [9];
  logic [SPAN_W-1:0] span_u = '0;
  logic [SPAN_W-1:0] span_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AREA_W-1:0] vapor_area;

  logic [AREA_W-1:0] area_q [$];
  int mismatches = 0;
  int cycles = 0;
  int stall_mode = 0;
  face_t dir [N_DIR];

  initial for (int i = 0; i < 9; i++) frac[i] = '0;

  always #5 clk = ~clk;

  face_vapor_area_marching_square u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cell_lo_lo  (frac[0]),
    .cell_mid_lo (frac[1]),
    .cell_hi_lo  (frac[2]),
    .cell_lo_mid (frac[3]),
    .cell_mid    (frac[4]),
    .cell_hi_mid (frac[5]),
    .cell_lo_hi  (frac[6]),
    .cell_mid_hi (frac[7]),
    .cell_hi_hi  (frac[8]),
    .span_u      (span_u),
    .span_v      (span_v),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vapor_area  (vapor_area)
  );

  function automatic longint unsigned crossing(longint unsigned span, longint unsigned cn,
                                               longint unsigned cf);
    longint unsigned num;
    longint unsigned den;
    num = (cn > HALF_SUM) ? cn - HALF_SUM : HALF_SUM - cn;
    den = (cf > cn) ? cf - cn : cn - cf;
    if (den == 0) return 0;
    return (2 * span * num + den) / (2 * den);
  endfunction

  function automatic longint tri_area2(fpt_t a, fpt_t b, fpt_t c);
    longint x;
    x = (b.u - a.u) * (c.v - a.v) - (b.v - a.v) * (c.u - a.u);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint hex_area2(fpt_t p [8]);
    return tri_area2(p[0], p[1], p[2]) + tri_area2(p[2], p[3], p[4])
         + tri_area2(p[4], p[5], p[0]) + tri_area2(p[0], p[2], p[4]);
  endfunction

  function automatic logic [AREA_W-1:0] vapor_area_of(face_t x);
    longint unsigned c [4];
    fpt_t pos [4];
    fpt_t pv [8];
    fpt_t pl [8];
    fpt_t p;
    bit below [4];
    int nv;
    int nl;
    int nb;
    int n;
    longint su;
    longint sv;
    longint face;
    longint d2;
    nv = 0;
    nl = 0;
    nb = 0;
    su = x.su;
    sv = x.sv;
    face = su * sv;
    c[0] = x.f[0] + x.f[1] + x.f[3] + x.f[4];
    c[1] = x.f[1] + x.f[2] + x.f[4] + x.f[5];
    c[2] = x.f[3] + x.f[4] + x.f[6] + x.f[7];
    c[3] = x.f[4] + x.f[5] + x.f[7] + x.f[8];
    pos[0] = '{0, 0};
    pos[1] = '{su, 0};
    pos[2] = '{0, sv};
    pos[3] = '{su, sv};
    for (int k = 0; k < 4; k++) begin
      below[k] = c[k] < HALF_SUM;
      if (below[k]) nb++;
    end
    if (nb == 4) return face[AREA_W-1:0];
    if (nb == 0) return '0;
    for (int k = 0; k < 4; k++) begin
      n = CYC_NODE[k];
      if (below[n]) begin
        pv[nv] = pos[n];
        nv++;
      end else begin
        pl[nl] = pos[n];
        nl++;
      end
      if (below[EDGE_LO[k]] != below[EDGE_HI[k]]) begin
        p = pos[EDGE_LO[k]];
        if (EDGE_ON_U[k]) p.u += longint'(crossing(su, c[EDGE_LO[k]], c[EDGE_HI[k]]));
        else p.v += longint'(crossing(sv, c[EDGE_LO[k]], c[EDGE_HI[k]]));
        pv[nv] = p;
        nv++;
        pl[nl] = p;
        nl++;
      end
    end
    case (nv)
      3: d2 = tri_area2(pv[0], pv[1], pv[2]);
      4: d2 = tri_area2(pv[0], pv[1], pv[2]) + tri_area2(pv[0], pv[2], pv[3]);
      5: d2 = 2 * face - tri_area2(pl[0], pl[1], pl[2]);
      6: begin
        if (x.f[4] < CENTRE_HALF) d2 = hex_area2(pv);
        else d2 = 2 * face - hex_area2(pl);
      end
      default: d2 = 0;
    endcase
    if (d2 < 0) d2 = 0;
    d2 = (d2 + 1) >>> 1;
    if (d2 > face) d2 = face;
    return d2[AREA_W-1:0];
  endfunction

  function automatic face_t row(int a0, int a1, int a2, int a3, int a4, int a5, int a6,
                                int a7, int a8, int su, int sv, bit known,
                                longint area);
    face_t r;
    r.f = '{FRAC_W'(a0), FRAC_W'(a1), FRAC_W'(a2), FRAC_W'(a3), FRAC_W'(a4),
            FRAC_W'(a5), FRAC_W'(a6), FRAC_W'(a7), FRAC_W'(a8)};
    r.su = SPAN_W'(su);
    r.sv = SPAN_W'(sv);
    r.known = known;
    r.area = AREA_W'(area);
    return r;
  endfunction

  function automatic face_t uniform_face(int v, int su, int sv, bit known, longint area);
    return row(v, v, v, v, v, v, v, v, v, su, sv, known, area);
  endfunction

  function automatic logic [FRAC_W-1:0] near_half();
    int d;
    d = $urandom_range(0, 24000);
    return 17'(32768 + d - 12000);
  endfunction

  function automatic face_t random_face();
    face_t r;
    int mode;
    int pick;
    int v;
    mode = $urandom_range(0, 9);
    v = $urandom_range(0, 65536);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        6: r.f[i] = FRAC_W'($urandom_range(0, 65536));
        7: r.f[i] = 17'($urandom);
        8: begin
          pick = $urandom_range(0, 3);
          r.f[i] = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd32768 :
                   (pick == 2) ? 17'd65536 : 17'h1FFFF;
        end
        9: r.f[i] = FRAC_W'(v);
        default: r.f[i] = near_half();
      endcase
    end
    pick = $urandom_range(0, 19);
    r.su = (pick == 0) ? 24'($urandom_range(0, 16)) : (pick == 1) ? 24'hFFFFFF :
           24'($urandom_range(1, 24'hFFFFFF));
    pick = $urandom_range(0, 19);
    r.sv = (pick == 0) ? 24'($urandom_range(0, 16)) : (pick == 1) ? 24'hFFFFFF :
           24'($urandom_range(1, 24'hFFFFFF));
    r.known = 1'b0;
    r.area = '0;
    return r;
  endfunction

  task automatic send_face(face_t x);
    for (int i = 0; i < 9; i++) frac[i] <= x.f[i];
    span_u <= x.su;
    span_v <= x.sv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    area_q.push_back(x.known ? x.area : vapor_area_of(x));
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycles % 7) != 3);
    endcase
    if (out_valid && out_ready) begin
      if (area_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word: vapor_area=%0d", vapor_area);
      end else begin
        if (vapor_area !== area_q[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("vapor_area: expected %0d, got %0d", area_q[0], vapor_area);
        end
        void'(area_q.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("face_vapor_area_marching_square: mismatch");
      $finish;
    end
  end

  initial begin
    dir[0] = uniform_face(0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 64'd281474943156225);
    dir[1] = uniform_face(65536, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 0);
    dir[2] = uniform_face(32768, 24'h010000, 24'h010000, 1'b1, 0);
    dir[3] = uniform_face(32767, 24'h010000, 24'h010000, 1'b1, 64'h1_0000_0000);
    dir[4] = uniform_face(131071, 24'hFFFFFF, 24'h000001, 1'b1, 0);
    dir[5] = uniform_face(0, 0, 24'hFFFFFF, 1'b1, 0);
    dir[6] = row(0, 32768, 65536, 32768, 0, 32768, 65536, 32768, 0,
                 24'h010000, 24'h020000, 1'b0, 0);
    dir[7] = row(0, 32768, 65536, 32768, 40000, 32768, 65536, 32768, 0,
                 24'h010000, 24'h020000, 1'b0, 0);
    dir[8] = row(65536, 32768, 0, 32768, 20000, 32768, 0, 32768, 65536,
                 24'h030000, 24'h010000, 1'b0, 0);
    dir[9] = row(0, 0, 65536, 0, 0, 65536, 65536, 65536, 65536,
                 24'h010000, 24'h010000, 1'b0, 0);
    dir[10] = row(0, 0, 0, 0, 0, 65536, 0, 65536, 65536,
                  24'h123456, 24'h654321, 1'b0, 0);
    dir[11] = row(0, 0, 0, 65536, 65536, 65536, 65536, 65536, 65536,
                  24'hFFFFFF, 24'hFFFFFF, 1'b0, 0);
    dir[12] = row(30000, 35000, 40000, 25000, 32768, 37000, 20000, 33000, 45000,
                  24'h00ABCD, 24'h0F0F0F, 1'b0, 0);
    dir[13] = row(131071, 0, 131071, 0, 131071, 0, 131071, 0, 131071,
                  24'h800000, 24'h7FFFFF, 1'b0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_face(dir[i]);
      idle_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      send_face(random_face());
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (area_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end else begin
        idle_gap();
      end
    end
    in_valid <= 1'b0;

    while (area_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && area_q.size() == 0) begin
      $display("face_vapor_area_marching_square: match");
    end else begin
      $display("face_vapor_area_marching_square: mismatch");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/fvams_pkg.sv
rtl/face_vapor_area_marching_square.sv
dv/tb.sv
